// File: sv/kalman_apogee_detector_top_assert.svh
// Assertion macros used by the apogee detector checker.
`ifndef KALMAN_APOGEE_DETECTOR_TOP_ASSERT_SVH
`define KALMAN_APOGEE_DETECTOR_TOP_ASSERT_SVH
// Same-cycle implication, disabled while reset is low.
`define KAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define KAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: sv/kad_pkg.sv
// Shared types, codes and saturation helper for the apogee detector.
`timescale 1ns / 1ps
package kad_pkg;

  localparam int WIDE_W = 72;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_INIT   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] CFG_TIME_STEP = 3'd0;
  localparam logic [2:0] CFG_ALT_NOISE = 3'd1;
  localparam logic [2:0] CFG_VEL_NOISE = 3'd2;
  localparam logic [2:0] CFG_MEAS_NOISE = 3'd3;
  localparam logic [2:0] CFG_MIN_ALT   = 3'd4;
  localparam logic [2:0] CFG_MAX_VEL   = 3'd5;
  localparam logic [2:0] CFG_CONFIRM   = 3'd6;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = {{(WIDE_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_MIN = {{(WIDE_W-31){1'b1}}, {31{1'b0}}};

  // One multiply step of the filter sequence.
  typedef enum logic [3:0] {
    ST_ZP, ST_P00A, ST_DT2, ST_P00, ST_P01,
    ST_ALT, ST_VEL, ST_VA, ST_CC, ST_VV
  } step_e;

  typedef struct packed {
    logic  load;
    logic  init;
    logic  clr_flag;
    logic  mul;
    logic  upd;
    logic  div_start;
    logic  take_gain;
    logic  detect;
    logic  publish;
    step_e step;
  } ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7FFFFFFF;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: sv/kalman_apogee_detector_top.sv
// Top level of the Kalman apogee detector: sequencer plus datapath.
// Usage: one input beat per barometer sample or command (cmd_i). A sample beat
// runs one predict and correct pass of a position and velocity filter and the
// apogee check; a reinitialize beat resets the filter; a clear beat drops the
// latched apogee flag. Every input beat yields exactly one output beat with the
// updated estimates, the flag and a new-detection bit.
// Processing: a sample beat runs through the two-lane divider, which produces one
// gain bit per cycle for each of its 32 + FRAC_BITS quotient bits, and the single
// shared multiplier used by ten multiply steps. One item is processed at a time,
// and the next is accepted as soon as the previous result sits in the output
// register.
// Configuration beats are always accepted; write them only while idle.
// Reset loads the default registers, zero estimates and unit covariance.
// If the receiver stalls, the output beat holds and a finished item waits
// in its final state until the output register frees up.
`timescale 1ns / 1ps
module kalman_apogee_detector_top #(
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] measured_altitude_i,
  input  logic               detect_enable_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] altitude_estimate_o,
  output logic signed [31:0] velocity_estimate_o,
  output logic               apogee_flag_o,
  output logic               apogee_new_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  kad_pkg::ctrl_t ctrl;
  logic           div_busy;

  assign cfg_ready_o = 1'b1;

  kad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .div_busy_i  (div_busy),
    .ctrl_o      (ctrl)
  );

  kad_datapath #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .div_busy_o  (div_busy),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .meas_i      (measured_altitude_i),
    .det_en_i    (detect_enable_i),
    .alt_o       (altitude_estimate_o),
    .vel_o       (velocity_estimate_o),
    .flag_o      (apogee_flag_o),
    .new_o       (apogee_new_o)
  );

endmodule

// File: sv/kad_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module kad_div #(
  parameter int FRAC_BITS = 16,
  parameter int DIV_W     = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [31:0]      num0_i,
  input  logic signed [31:0]      num1_i,
  input  logic        [32:0]      den_i,
  output logic                    busy_o,
  output logic        [DIV_W-1:0] quot0_o,
  output logic        [DIV_W-1:0] quot1_o,
  output logic                    neg0_o,
  output logic                    neg1_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [32:0]      den_q;
  logic [DIV_W-1:0] d0_q, d1_q, q0_q, q1_q;
  logic [32:0]      rem0_q, rem1_q;
  logic             neg0_q, neg1_q;

  logic [33:0] sh0, sh1;
  logic        ge0, ge1;
  logic [33:0] sub0, sub1;
  logic [31:0] mag0, mag1;

  assign mag0 = num0_i[31] ? 32'(-num0_i) : 32'(num0_i);
  assign mag1 = num1_i[31] ? 32'(-num1_i) : 32'(num1_i);

  always_comb begin
    sh0  = {rem0_q, d0_q[DIV_W-1]};
    sh1  = {rem1_q, d1_q[DIV_W-1]};
    ge0  = sh0 >= {1'b0, den_q};
    ge1  = sh1 >= {1'b0, den_q};
    sub0 = ge0 ? sh0 - {1'b0, den_q} : sh0;
    sub1 = ge1 ? sh1 - {1'b0, den_q} : sh1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      d0_q   <= {mag0, {FRAC_BITS{1'b0}}};
      d1_q   <= {mag1, {FRAC_BITS{1'b0}}};
      q0_q   <= '0;
      q1_q   <= '0;
      rem0_q <= '0;
      rem1_q <= '0;
      neg0_q <= num0_i[31];
      neg1_q <= num1_i[31];
    end else if (busy_q) begin
      d0_q   <= {d0_q[DIV_W-2:0], 1'b0};
      d1_q   <= {d1_q[DIV_W-2:0], 1'b0};
      q0_q   <= {q0_q[DIV_W-2:0], ge0};
      q1_q   <= {q1_q[DIV_W-2:0], ge1};
      rem0_q <= sub0[32:0];
      rem1_q <= sub1[32:0];
    end
  end

  assign busy_o  = busy_q;
  assign quot0_o = q0_q;
  assign quot1_o = q1_q;
  assign neg0_o  = neg0_q;
  assign neg1_o  = neg1_q;

endmodule

// File: sv/kad_datapath.sv
// Filter datapath: registers, shared multiplier, divider and apogee check.
`timescale 1ns / 1ps
module kad_datapath #(
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kad_pkg::ctrl_t      ctrl_i,
  output logic                div_busy_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic signed [31:0]  meas_i,
  input  logic                det_en_i,
  output logic signed [31:0]  alt_o,
  output logic signed [31:0]  vel_o,
  output logic                flag_o,
  output logic                new_o
);

  localparam int W     = kad_pkg::WIDE_W;
  localparam int DIV_W = 32 + FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [W-1:0] HALF = {{(W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // Configuration registers.
  logic [15:0]        dt_q;
  logic [22:0]        aq_q, vq_q, rn_q;
  logic signed [31:0] min_alt_q, max_vel_q;
  logic [7:0]         confirm_q;

  // Filter state.
  logic signed [31:0]     alt_q, vel_q, va_q, cc_q, vv_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic                   latched_q, fresh_q;

  // Working registers.
  logic signed [31:0]  meas_q, zp_q, p00_q, p01_q, p11_q, y_q, k0_q, k1_q;
  logic                det_en_q, s_pos_q;
  logic signed [W-1:0] acc_q;
  logic signed [32:0]  t_q;
  logic signed [65:0]  prod_q;

  logic signed [31:0] o_alt_q, o_vel_q;
  logic               o_flag_q, o_new_q;

  logic signed [32:0]  opa, opb, dt_s;
  logic signed [W-1:0] rnd;
  logic signed [33:0]  s_w;
  logic                s_pos;
  logic [DIV_W-1:0]    quot0, quot1;
  logic                neg0, neg1;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                qualify;

  function automatic logic signed [31:0] sat_quot(input logic neg, input logic [DIV_W-1:0] q);
    logic signed [31:0] r;
    if (!neg) r = (q > DIV_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(q[31:0]);
    else r = (q > DIV_W'(32'h80000000)) ? 32'sh80000000 : $signed(-q[31:0]);
    return r;
  endfunction

  assign dt_s = $signed({17'b0, dt_q});

  always_comb begin
    case (ctrl_i.step)
      kad_pkg::ST_ZP:   begin opa = {vel_q[31], vel_q}; opb = dt_s; end
      kad_pkg::ST_P00A: begin opa = dt_s; opb = {cc_q, 1'b0}; end
      kad_pkg::ST_DT2:  begin opa = dt_s; opb = dt_s; end
      kad_pkg::ST_P00:  begin opa = t_q; opb = {vv_q[31], vv_q}; end
      kad_pkg::ST_P01:  begin opa = dt_s; opb = {vv_q[31], vv_q}; end
      kad_pkg::ST_ALT:  begin opa = {k0_q[31], k0_q}; opb = {y_q[31], y_q}; end
      kad_pkg::ST_VEL:  begin opa = {k1_q[31], k1_q}; opb = {y_q[31], y_q}; end
      kad_pkg::ST_VA:   begin opa = {k0_q[31], k0_q}; opb = {p00_q[31], p00_q}; end
      kad_pkg::ST_CC:   begin opa = {k0_q[31], k0_q}; opb = {p01_q[31], p01_q}; end
      kad_pkg::ST_VV:   begin opa = {k1_q[31], k1_q}; opb = {p01_q[31], p01_q}; end
      default:          begin opa = '0; opb = '0; end
    endcase
  end

  // Round to nearest, ties upward, then floor shift.
  assign rnd   = (W'(prod_q) + HALF) >>> FRAC_BITS;
  assign s_w   = {{2{p00_q[31]}}, p00_q} + $signed({11'b0, rn_q});
  assign s_pos = !s_w[33] && (s_w != '0);

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign qualify = (alt_q > min_alt_q) && (vel_q < max_vel_q);

  kad_div #(.FRAC_BITS(FRAC_BITS), .DIV_W(DIV_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.div_start && s_pos),
    .num0_i  (p00_q),
    .num1_i  (p01_q),
    .den_i   (s_w[32:0]),
    .busy_o  (div_busy_o),
    .quot0_o (quot0),
    .quot1_o (quot1),
    .neg0_o  (neg0),
    .neg1_o  (neg1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q      <= 16'd2621;
      aq_q      <= 23'd6554;
      vq_q      <= 23'd32768;
      rn_q      <= 23'd65536;
      min_alt_q <= 32'sd983040;
      max_vel_q <= -32'sd65536;
      confirm_q <= 8'd5;
      alt_q     <= '0;
      vel_q     <= '0;
      va_q      <= ONE;
      cc_q      <= '0;
      vv_q      <= ONE;
      cnt_q     <= '0;
      latched_q <= 1'b0;
      fresh_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          kad_pkg::CFG_TIME_STEP:  dt_q      <= cfg_data_i[15:0];
          kad_pkg::CFG_ALT_NOISE:  aq_q      <= cfg_data_i[22:0];
          kad_pkg::CFG_VEL_NOISE:  vq_q      <= cfg_data_i[22:0];
          kad_pkg::CFG_MEAS_NOISE: rn_q      <= cfg_data_i[22:0];
          kad_pkg::CFG_MIN_ALT:    min_alt_q <= $signed(cfg_data_i);
          kad_pkg::CFG_MAX_VEL:    max_vel_q <= $signed(cfg_data_i);
          kad_pkg::CFG_CONFIRM:    confirm_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (ctrl_i.load) fresh_q <= 1'b0;
      if (ctrl_i.init) begin
        alt_q     <= '0;
        vel_q     <= '0;
        va_q      <= ONE;
        cc_q      <= '0;
        vv_q      <= ONE;
        cnt_q     <= '0;
        latched_q <= 1'b0;
      end
      if (ctrl_i.clr_flag) latched_q <= 1'b0;
      if (ctrl_i.upd) begin
        case (ctrl_i.step)
          kad_pkg::ST_ALT: alt_q <= kad_pkg::sat32(W'(zp_q) + rnd);
          kad_pkg::ST_VEL: vel_q <= kad_pkg::sat32(W'(vel_q) + rnd);
          kad_pkg::ST_VA:  va_q  <= kad_pkg::sat32(W'(p00_q) - rnd);
          kad_pkg::ST_CC:  cc_q  <= kad_pkg::sat32(W'(p01_q) - rnd);
          kad_pkg::ST_VV:  vv_q  <= kad_pkg::sat32(W'(p11_q) - rnd);
          default: ;
        endcase
      end
      if (ctrl_i.detect && det_en_q) begin
        if (qualify) begin
          cnt_q <= cnt_inc;
          if ((17'(cnt_inc) >= 17'(confirm_q)) && !latched_q) begin
            latched_q <= 1'b1;
            fresh_q   <= 1'b1;
          end
        end else begin
          cnt_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      meas_q   <= meas_i;
      det_en_q <= det_en_i;
    end
    if (ctrl_i.mul) prod_q <= opa * opb;
    if (ctrl_i.upd) begin
      case (ctrl_i.step)
        kad_pkg::ST_ZP:   zp_q  <= kad_pkg::sat32(W'(alt_q) + rnd);
        kad_pkg::ST_P00A: acc_q <= W'(va_q) + rnd + $signed(W'(aq_q));
        kad_pkg::ST_DT2:  t_q   <= rnd[32:0];
        kad_pkg::ST_P00:  p00_q <= kad_pkg::sat32(acc_q + rnd);
        kad_pkg::ST_P01: begin
          p01_q <= kad_pkg::sat32(W'(cc_q) + rnd);
          p11_q <= kad_pkg::sat32(W'(vv_q) + $signed(W'(vq_q)));
        end
        default: ;
      endcase
    end
    if (ctrl_i.div_start) begin
      s_pos_q <= s_pos;
      y_q     <= kad_pkg::sat32(W'(meas_q) - W'(zp_q));
    end
    if (ctrl_i.take_gain) begin
      k0_q <= s_pos_q ? sat_quot(neg0, quot0) : '0;
      k1_q <= s_pos_q ? sat_quot(neg1, quot1) : '0;
    end
    if (ctrl_i.publish) begin
      o_alt_q  <= alt_q;
      o_vel_q  <= vel_q;
      o_flag_q <= latched_q;
      o_new_q  <= fresh_q;
    end
  end

  assign alt_o  = o_alt_q;
  assign vel_o  = o_vel_q;
  assign flag_o = o_flag_q;
  assign new_o  = o_new_q;

endmodule

// File: sv/kad_ctrl.sv
// Sequencer that steps the filter datapath and owns the channel handshakes.
`timescale 1ns / 1ps
module kad_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     cmd_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  logic           div_busy_i,
  output kad_pkg::ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_UPD, S_DIV, S_DWAIT, S_GAIN, S_DET, S_PUB
  } state_e;

  state_e         state_q;
  kad_pkg::step_e step_q;
  logic           out_valid_q;
  logic           accept, pub_ok;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign pub_ok = (state_q == S_PUB) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.step      = step_q;
    ctrl_o.load      = accept;
    ctrl_o.init      = accept && (cmd_i == kad_pkg::CMD_INIT);
    ctrl_o.clr_flag  = accept && (cmd_i == kad_pkg::CMD_CLEAR);
    ctrl_o.mul       = (state_q == S_MUL);
    ctrl_o.upd       = (state_q == S_UPD);
    ctrl_o.div_start = (state_q == S_DIV);
    ctrl_o.take_gain = (state_q == S_GAIN);
    ctrl_o.detect    = (state_q == S_DET);
    ctrl_o.publish   = pub_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= kad_pkg::ST_ZP;
      out_valid_q <= 1'b0;
    end else begin
      if (pub_ok) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            step_q  <= kad_pkg::ST_ZP;
            state_q <= (cmd_i == kad_pkg::CMD_SAMPLE) ? S_MUL : S_PUB;
          end
        end
        S_MUL: state_q <= S_UPD;
        S_UPD: begin
          case (step_q)
            kad_pkg::ST_ZP:   begin step_q <= kad_pkg::ST_P00A; state_q <= S_MUL; end
            kad_pkg::ST_P00A: begin step_q <= kad_pkg::ST_DT2;  state_q <= S_MUL; end
            kad_pkg::ST_DT2:  begin step_q <= kad_pkg::ST_P00;  state_q <= S_MUL; end
            kad_pkg::ST_P00:  begin step_q <= kad_pkg::ST_P01;  state_q <= S_MUL; end
            kad_pkg::ST_P01:  state_q <= S_DIV;
            kad_pkg::ST_ALT:  begin step_q <= kad_pkg::ST_VEL;  state_q <= S_MUL; end
            kad_pkg::ST_VEL:  begin step_q <= kad_pkg::ST_VA;   state_q <= S_MUL; end
            kad_pkg::ST_VA:   begin step_q <= kad_pkg::ST_CC;   state_q <= S_MUL; end
            kad_pkg::ST_CC:   begin step_q <= kad_pkg::ST_VV;   state_q <= S_MUL; end
            kad_pkg::ST_VV:   state_q <= S_DET;
            default:          state_q <= S_IDLE;
          endcase
        end
        S_DIV:   state_q <= S_DWAIT;
        S_DWAIT: if (!div_busy_i) state_q <= S_GAIN;
        S_GAIN: begin
          step_q  <= kad_pkg::ST_ALT;
          state_q <= S_MUL;
        end
        S_DET: state_q <= S_PUB;
        S_PUB: if (pub_ok) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/kad_checker.sv
// Port-level checker for the apogee detector, bound to the top level.
`timescale 1ns / 1ps
`include "kalman_apogee_detector_top_assert.svh"
module kad_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] altitude_estimate_o,
  input logic signed [31:0] velocity_estimate_o,
  input logic               apogee_flag_o,
  input logic               apogee_new_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o
);

  logic [65:0] out_beat;

  assign out_beat = {altitude_estimate_o, velocity_estimate_o, apogee_flag_o, apogee_new_o};

  // A fresh detection always comes with the latched flag.
  `KAD_ASSERT_NOW(a_new_has_flag, out_valid_o && apogee_new_o, apogee_flag_o, "new without flag")
  `KAD_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o, "config beat refused")
  `KAD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output valid dropped")
  `KAD_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_beat), "stalled output changed")

endmodule

bind kalman_apogee_detector_top kad_checker u_kad_checker (.*);

// File: tb/kalman_apogee_detector_top_tb.sv
// Self-checking testbench for the Kalman apogee detector top level.
`timescale 1ns / 1ps
module kalman_apogee_detector_top_tb;

  localparam longint QONE = 64'sd65536;
  localparam longint I32MAX = 64'sd2147483647;
  localparam longint I32MIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [31:0] altitude;
    logic signed [31:0] velocity;
    logic               flag;
    logic               fresh;
  } estimate_t;

  class estimate_board;
    estimate_t pending[$];
    int        mismatches;
    int        matched;

    function void note(estimate_t e);
      pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    task check(estimate_t got);
      estimate_t want;
      if (pending.size() == 0) begin
        report("unexpected result beat", 1, 0);
      end else begin
        want = pending.pop_front();
        matched++;
        if (got.altitude !== want.altitude) report("altitude", got.altitude, want.altitude);
        if (got.velocity !== want.velocity) report("velocity", got.velocity, want.velocity);
        if (got.flag !== want.flag) report("apogee flag", got.flag, want.flag);
        if (got.fresh !== want.fresh) report("apogee new", got.fresh, want.fresh);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = kad_pkg::CMD_SAMPLE;
  logic signed [31:0] measured_altitude_i = '0;
  logic detect_enable_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] altitude_estimate_o;
  logic signed [31:0] velocity_estimate_o;
  logic apogee_flag_o;
  logic apogee_new_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = kad_pkg::CFG_TIME_STEP;
  logic [31:0] cfg_data_i = '0;

  kalman_apogee_detector_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  estimate_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int calm = 0;
  int items_sent = 0;
  int latches_seen = 0;
  int cycles = 0;

  // Filter state and registers mirrored by the predictor.
  longint ts, q_alt, q_vel, r_meas, min_alt, max_vel, confirm;
  longint x_alt, x_vel, p_aa, p_av, p_vv;
  int unsigned qual;
  logic latched;

  function automatic longint clamp32(longint v);
    if (v > I32MAX) return I32MAX;
    if (v < I32MIN) return I32MIN;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint qdiv(longint num, longint den);
    return clamp32((num * QONE) / den);
  endfunction

  function void filter_clear();
    x_alt = 0; x_vel = 0; p_aa = QONE; p_av = 0; p_vv = QONE;
    qual = 0; latched = 1'b0;
  endfunction

  function void apply_register(logic [2:0] idx, logic [31:0] data);
    case (idx)
      kad_pkg::CFG_TIME_STEP:  ts = data[15:0];
      kad_pkg::CFG_ALT_NOISE:  q_alt = data[22:0];
      kad_pkg::CFG_VEL_NOISE:  q_vel = data[22:0];
      kad_pkg::CFG_MEAS_NOISE: r_meas = data[22:0];
      kad_pkg::CFG_MIN_ALT:    min_alt = longint'($signed(data));
      kad_pkg::CFG_MAX_VEL:    max_vel = longint'($signed(data));
      kad_pkg::CFG_CONFIRM:    confirm = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic estimate_t predict_estimate(logic [1:0] cmd, logic signed [31:0] meas,
                                                 logic en);
    estimate_t e;
    longint zp, p00, p01, p11, s, k0, k1, y;
    logic fresh;
    fresh = 1'b0;
    if (cmd == kad_pkg::CMD_SAMPLE) begin
      zp = clamp32(x_alt + qmul(x_vel, ts));
      p00 = clamp32(p_aa + qmul(ts, 2 * p_av) + qmul(qmul(ts, ts), p_vv) + q_alt);
      p01 = clamp32(p_av + qmul(ts, p_vv));
      p11 = clamp32(p_vv + q_vel);
      s = p00 + r_meas;
      k0 = 0;
      k1 = 0;
      if (s > 0) begin
        k0 = qdiv(p00, s);
        k1 = qdiv(p01, s);
      end
      y = clamp32(longint'(meas) - zp);
      x_alt = clamp32(zp + qmul(k0, y));
      x_vel = clamp32(x_vel + qmul(k1, y));
      p_aa = clamp32(p00 - qmul(k0, p00));
      p_av = clamp32(p01 - qmul(k0, p01));
      p_vv = clamp32(p11 - qmul(k1, p01));
      if (en) begin
        if (x_alt > min_alt && x_vel < max_vel) begin
          if (qual < 255) qual++;
          if (qual >= confirm && !latched) begin
            latched = 1'b1;
            fresh = 1'b1;
          end
        end else begin
          qual = 0;
        end
      end
    end else if (cmd == kad_pkg::CMD_INIT) begin
      filter_clear();
    end else if (cmd == kad_pkg::CMD_CLEAR) begin
      latched = 1'b0;
    end
    e.altitude = x_alt[31:0];
    e.velocity = x_vel[31:0];
    e.flag = latched;
    e.fresh = fresh;
    return e;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= (calm > 0) || ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    estimate_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.altitude = altitude_estimate_o;
      got.velocity = velocity_estimate_o;
      got.flag = apogee_flag_o;
      got.fresh = apogee_new_o;
      if (apogee_new_o) latches_seen++;
      board.check(got);
    end
  end

  // Drives one input beat; the beat before it has already been accepted.
  task send_item(logic [1:0] cmd, logic signed [31:0] meas, logic en);
    @(negedge clk_i);
    if (calm > 0) calm--;
    else if ($urandom_range(59) == 0) calm = $urandom_range(10, 40);
    while (calm == 0 && $urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    cmd_i = cmd;
    measured_altitude_i = meas;
    detect_enable_i = en;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note(predict_estimate(cmd, meas, en));
    items_sent++;
  endtask

  task drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  task write_register(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task write_settings(longint t, longint qa, longint qv, longint r, longint ma, longint mv,
                      longint c);
    drain();
    repeat (8) @(negedge clk_i);
    write_register(kad_pkg::CFG_TIME_STEP, t[31:0]);
    write_register(kad_pkg::CFG_ALT_NOISE, qa[31:0]);
    write_register(kad_pkg::CFG_VEL_NOISE, qv[31:0]);
    write_register(kad_pkg::CFG_MEAS_NOISE, r[31:0]);
    write_register(kad_pkg::CFG_MIN_ALT, ma[31:0]);
    write_register(kad_pkg::CFG_MAX_VEL, mv[31:0]);
    write_register(kad_pkg::CFG_CONFIRM, c[31:0]);
  endtask

  // A ballistic climb and fall sampled with a little measurement noise.
  task fly(int n);
    longint g_step, v, alt, m;
    g_step = (64'sd642253 * ts) >>> 16;
    v = g_step * n / 2;
    alt = 0;
    send_item(kad_pkg::CMD_INIT, '0, 1'b0);
    for (int i = 0; i < n; i++) begin
      m = clamp32(alt + $signed($urandom_range(131072)) - 65536);
      send_item(kad_pkg::CMD_SAMPLE, m[31:0], (i > n / 4) ? 1'b1 : 1'(($urandom_range(1))));
      if ($urandom_range(39) == 0) begin
        send_item(kad_pkg::CMD_CLEAR, $urandom, 1'($urandom_range(1)));
      end
      alt = alt + ((v * ts) >>> 16);
      v = v - g_step;
    end
  endtask

  task noise_item();
    logic [31:0] m;
    m = ($urandom_range(1)) ? $urandom : 32'($signed($urandom_range(2000000)) - 1000000);
    send_item(2'($urandom_range(3)), m, 1'($urandom_range(1)));
  endtask

  initial begin
    int target;
    ts = 2621; q_alt = 6554; q_vel = 32768; r_meas = 65536;
    min_alt = 983040; max_vel = -65536; confirm = 5;
    filter_clear();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every command, innovation saturation.
    send_item(kad_pkg::CMD_SAMPLE, 32'sh7FFFFFFF, 1'b1);
    send_item(kad_pkg::CMD_SAMPLE, 32'sh80000000, 1'b1);
    send_item(kad_pkg::CMD_SAMPLE, 32'sh7FFFFFFF, 1'b0);
    send_item(kad_pkg::CMD_SAMPLE, '0, 1'b1);
    send_item(kad_pkg::CMD_UNUSED, 32'hFFFFFFFF, 1'b1);
    send_item(kad_pkg::CMD_CLEAR, '0, 1'b0);
    send_item(kad_pkg::CMD_INIT, 32'h55555555, 1'b1);
    for (int i = 0; i < 8; i++) send_item(kad_pkg::CMD_SAMPLE, 32'sd6553600, 1'b1);
    for (int i = 0; i < 6; i++) begin
      send_item(kad_pkg::CMD_SAMPLE, 32'sd6553600 - i * 32'sd3000000, 1'b1);
    end
    send_item(kad_pkg::CMD_CLEAR, '0, 1'b1);
    send_item(kad_pkg::CMD_SAMPLE, 32'sd1000, 1'b1);
    send_item(kad_pkg::CMD_INIT, '0, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      send_idle = (phase < 2) ? 29 : (phase < 4) ? 55 : 0;
      recv_idle = (phase < 2) ? 55 : (phase < 4) ? 29 : 0;
      case (phase)
        0: write_settings(1, 0, 0, 1, I32MIN, I32MIN, 1);
        1: write_settings(65535, 4194304, 4194304, 4194304, I32MAX, I32MAX, 255);
        // Always qualifying with the longest confirmation: the counter saturates.
        3: write_settings(2621, 6554, 32768, 65536, I32MIN, I32MAX, 255);
        default: write_settings($urandom_range(1000, 8000), $urandom_range(20000),
                                $urandom_range(100000), $urandom_range(1, 200000),
                                $urandom_range(6553600), -longint'($urandom_range(131072)),
                                $urandom_range(1, 10));
      endcase
      target = items_sent + 310;
      if (phase == 3) begin
        send_item(kad_pkg::CMD_INIT, '0, 1'b0);
        for (int i = 0; i < 270; i++) begin
          send_item(kad_pkg::CMD_SAMPLE, $urandom, 1'b1);
          if (i == 262) send_item(kad_pkg::CMD_CLEAR, '0, 1'b0);
        end
      end
      while (items_sent < target) begin
        if (items_sent > target - 150 && items_sent < target - 140) drain();
        if ($urandom_range(99) < 65) fly($urandom_range(20, 80));
        else noise_item();
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d input beats over six register settings and three idling mixes;",
             items_sent);
    $display("checked %0d result beats, %0d new apogee detections.", board.matched,
             latches_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
